// File: hdl/afn_pkg.sv
// shared types and constants for the alarm match and next-alarm finder
`default_nettype none
package afn_pkg;

  localparam int ALARM_COUNT_MAX = 4;
  localparam int ALARM_COUNT_DEF = 4;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int INDEX_W  = 2;
  localparam int COUNT_W  = 3;
  localparam int SLOT_W   = HOUR_W + MINUTE_W;

  localparam int CFG_DATA_W  = SLOT_W * ALARM_COUNT_MAX;
  localparam int CFG_INDEX_W = 1;

  // minutes-of-day values and signed distances fit in 12 bits
  localparam int TOTAL_W = 12;

  localparam logic [TOTAL_W-1:0] MIN_PER_HOUR = TOTAL_W'(60);
  localparam logic [TOTAL_W-1:0] DAY_MINUTES  = TOTAL_W'(24 * 60);
  localparam logic [TOTAL_W-1:0] BEST_INIT    = TOTAL_W'(24 * 60 + 1);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_TIMES = 1'b1;

  typedef struct packed {
    logic [YEAR_W-1:0]   now_year;
    logic [MONTH_W-1:0]  now_month;
    logic [DAY_W-1:0]    now_day;
    logic [HOUR_W-1:0]   clock_hour;
    logic [MINUTE_W-1:0] clock_minute;
    logic                mark_fired;
  } tick_t;

  typedef struct packed {
    logic                match_found;
    logic [INDEX_W-1:0]  match_index;
    logic [COUNT_W-1:0]  match_count;
    logic                already_fired;
    logic                next_found;
    logic [INDEX_W-1:0]  next_index;
    logic [COUNT_W-1:0]  next_count;
    logic [HOUR_W-1:0]   next_hour;
    logic [MINUTE_W-1:0] next_minute;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/afn_tick_if.sv
// valid/ready channel carrying one date-time tick
`default_nettype none
interface afn_tick_if import afn_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/afn_result_if.sv
// valid/ready channel carrying one match and next-alarm result
`default_nettype none
interface afn_result_if import afn_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/alarm_match_and_next_finder.sv
// Daily alarm bank: current-minute match and nearest upcoming alarm search.
// Channels: tick (sink) takes a date-time item, result (source) gives one
// result item per tick. Configuration is a plain write port: cfg_index 0
// writes the enable mask, cfg_index 1 writes the packed hour/minute slots.
// The user must write configuration only while no tick is in flight; the block does not enforce this.
// A tick is captured in an input register and moves into the result register,
// which raises result.valid. Throughput is one tick per cycle while the
// receiver takes results; the compare chain over the alarm slots between
// the two registers sets the clock.
// The fired record is updated as the tick moves into the result register,
// so the next tick already sees it.
// Reset clears the enable mask, the alarm times, the fired record and both
// pipeline valid flags. When the receiver stalls, the result register holds
// and the input register keeps one more tick; tick.ready then drops until
// the result is taken.
`default_nettype none
module alarm_match_and_next_finder import afn_pkg::*; #(
  parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  afn_tick_if.sink                    tick,
  afn_result_if.source                result
);

  logic [ALARM_COUNT-1:0] alarm_enable;
  logic [HOUR_W-1:0]      alarm_hour   [ALARM_COUNT];
  logic [MINUTE_W-1:0]    alarm_minute [ALARM_COUNT];

  logic                s1_valid;
  tick_t               s1_item;
  logic                result_valid;
  result_t             result_data;
  result_t             result_next;
  logic                advance;

  logic                fired_valid;
  logic [YEAR_W-1:0]   fired_year;
  logic [MONTH_W-1:0]  fired_month;
  logic [DAY_W-1:0]    fired_day;
  logic [HOUR_W-1:0]   fired_hour;
  logic [MINUTE_W-1:0] fired_minute;

  assign advance      = s1_valid && (!result_valid || result.ready);
  assign tick.ready   = !s1_valid || advance;
  assign result.valid = result_valid;
  assign result.data  = result_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_enable <= '0;
      for (int i = 0; i < ALARM_COUNT; i++) begin
        alarm_hour[i]   <= '0;
        alarm_minute[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE_MASK: begin
          alarm_enable <= cfg_data[ALARM_COUNT-1:0];
        end
        REG_ALARM_TIMES: begin
          for (int i = 0; i < ALARM_COUNT; i++) begin
            alarm_hour[i]   <= cfg_data[SLOT_W*i +: HOUR_W];
            alarm_minute[i] <= cfg_data[SLOT_W*i + HOUR_W +: MINUTE_W];
          end
        end
        default: begin
          alarm_enable <= alarm_enable;
        end
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      fired_valid  <= 1'b0;
    end else begin
      if (tick.ready) begin
        s1_valid <= tick.valid;
      end
      if (!result_valid || result.ready) begin
        result_valid <= s1_valid;
      end
      if (advance && s1_item.mark_fired) begin
        fired_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_item <= tick.data;
    end
    if (advance) begin
      result_data <= result_next;
    end
    if (advance && s1_item.mark_fired) begin
      fired_year   <= s1_item.now_year;
      fired_month  <= s1_item.now_month;
      fired_day    <= s1_item.now_day;
      fired_hour   <= s1_item.clock_hour;
      fired_minute <= s1_item.clock_minute;
    end
  end

  // match and nearest-alarm search over the bank
  always_comb begin
    logic                      same;
    logic signed [TOTAL_W-1:0] tick_mins;
    logic signed [TOTAL_W-1:0] slot_mins;
    logic signed [TOTAL_W-1:0] delta;
    logic signed [TOTAL_W-1:0] best;

    same = fired_valid && fired_year == s1_item.now_year &&
           fired_month == s1_item.now_month && fired_day == s1_item.now_day &&
           fired_hour == s1_item.clock_hour && fired_minute == s1_item.clock_minute;
    tick_mins = signed'(TOTAL_W'(s1_item.clock_hour) * MIN_PER_HOUR +
                        TOTAL_W'(s1_item.clock_minute));
    best = signed'(BEST_INIT);

    result_next = '0;
    result_next.already_fired = same;
    result_next.next_hour     = s1_item.clock_hour;
    result_next.next_minute   = s1_item.clock_minute;

    for (int i = 0; i < ALARM_COUNT; i++) begin
      slot_mins = signed'(TOTAL_W'(alarm_hour[i]) * MIN_PER_HOUR +
                          TOTAL_W'(alarm_minute[i]));
      delta = slot_mins - tick_mins;
      if (delta <= 0) begin
        delta = delta + signed'(DAY_MINUTES);
      end
      if (alarm_enable[i]) begin
        if (alarm_hour[i] == s1_item.clock_hour &&
            alarm_minute[i] == s1_item.clock_minute) begin
          if (!result_next.match_found) begin
            result_next.match_found = 1'b1;
            result_next.match_index = INDEX_W'(i);
          end
          result_next.match_count = result_next.match_count + COUNT_W'(1);
        end
        // an alarm a full day away is this minute, skipped once fired
        if (!(delta == signed'(DAY_MINUTES) && same)) begin
          if (delta < best) begin
            best                    = delta;
            result_next.next_found  = 1'b1;
            result_next.next_index  = INDEX_W'(i);
            result_next.next_count  = COUNT_W'(1);
            result_next.next_hour   = alarm_hour[i];
            result_next.next_minute = alarm_minute[i];
          end else if (delta == best && result_next.next_found &&
                       alarm_hour[i] == result_next.next_hour &&
                       alarm_minute[i] == result_next.next_minute) begin
            result_next.next_count = result_next.next_count + COUNT_W'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/afn_scoreboard_pkg.sv
// scoreboard class: alarm bank mirror, fired record and expected result queue
`timescale 1ns / 1ps
package afn_scoreboard_pkg;
  import afn_pkg::*;

  class alarm_scoreboard;
    logic [ALARM_COUNT_MAX-1:0] enable_mask;
    logic [CFG_DATA_W-1:0]      alarm_times;
    bit                         fired_valid;
    tick_t                      fired_tick;
    result_t                    expected_results[$];
    int                         failures;

    function new();
      enable_mask = '0;
      alarm_times = '0;
      fired_valid = 1'b0;
      fired_tick  = '0;
      failures    = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENABLE_MASK: enable_mask = data[ALARM_COUNT_MAX-1:0];
        REG_ALARM_TIMES: alarm_times = data;
        default: ;
      endcase
    endfunction

    // match and nearest-alarm search, then the fired record update
    function result_t predict_alarms(tick_t t);
      result_t r;
      bit      same;
      int      tick_mins;
      int      best;
      int      delta;
      int      ah;
      int      am;
      int      i;
      r = '0;
      same = fired_valid && fired_tick.now_year == t.now_year &&
             fired_tick.now_month == t.now_month && fired_tick.now_day == t.now_day &&
             fired_tick.clock_hour == t.clock_hour &&
             fired_tick.clock_minute == t.clock_minute;
      r.already_fired = same;
      r.next_hour     = t.clock_hour;
      r.next_minute   = t.clock_minute;
      best      = int'(BEST_INIT);
      tick_mins = int'(t.clock_hour) * int'(MIN_PER_HOUR) + int'(t.clock_minute);
      for (i = 0; i < ALARM_COUNT_DEF; i++) begin
        if (!enable_mask[i]) continue;
        ah = int'(alarm_times[SLOT_W*i +: HOUR_W]);
        am = int'(alarm_times[SLOT_W*i + HOUR_W +: MINUTE_W]);
        if (ah == int'(t.clock_hour) && am == int'(t.clock_minute)) begin
          if (!r.match_found) begin
            r.match_found = 1'b1;
            r.match_index = INDEX_W'(i);
          end
          r.match_count = r.match_count + 1'b1;
        end
        delta = ah * int'(MIN_PER_HOUR) + am - tick_mins;
        if (delta <= 0) delta += int'(DAY_MINUTES);
        // an alarm at this very minute is skipped once the minute has fired
        if (delta == int'(DAY_MINUTES) && same) continue;
        if (delta < best) begin
          best          = delta;
          r.next_found  = 1'b1;
          r.next_index  = INDEX_W'(i);
          r.next_count  = COUNT_W'(1);
          r.next_hour   = HOUR_W'(ah);
          r.next_minute = MINUTE_W'(am);
        end else if (delta == best && r.next_found && ah == int'(r.next_hour) &&
                     am == int'(r.next_minute)) begin
          r.next_count = r.next_count + 1'b1;
        end
      end
      if (t.mark_fired) begin
        fired_valid = 1'b1;
        fired_tick  = t;
      end
      return r;
    endfunction

    function void note_tick(tick_t t);
      expected_results.push_back(predict_alarms(t));
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result item with no tick pending");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      check_field("match_found", 8'(want.match_found), 8'(got.match_found));
      check_field("match_index", 8'(want.match_index), 8'(got.match_index));
      check_field("match_count", 8'(want.match_count), 8'(got.match_count));
      check_field("already_fired", 8'(want.already_fired), 8'(got.already_fired));
      check_field("next_found", 8'(want.next_found), 8'(got.next_found));
      check_field("next_index", 8'(want.next_index), 8'(got.next_index));
      check_field("next_count", 8'(want.next_count), 8'(got.next_count));
      check_field("next_hour", 8'(want.next_hour), 8'(got.next_hour));
      check_field("next_minute", 8'(want.next_minute), 8'(got.next_minute));
    endfunction
  endclass

endpackage

// File: tb/sv/alarm_match_and_next_finder_tb.sv
// testbench top: drives ticks and alarm settings, checks every result item
`timescale 1ns / 1ps
module alarm_match_and_next_finder_tb;
  import afn_pkg::*;
  import afn_scoreboard_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 100;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  afn_tick_if   tick_ch ();
  afn_result_if result_ch ();

  alarm_match_and_next_finder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  alarm_scoreboard sb;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    quiet_cycles  = 0;
  tick_t last_tick;
  bit    have_last     = 1'b0;

  always #1 clk = ~clk;

  // receiver stalls
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready) sb.note_tick(tick_ch.data);
      if (result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("alarm_match_and_next_finder_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_t make_tick(int year, int month, int day, int hour, int minute,
                                      bit mark);
    tick_t t;
    t.now_year     = YEAR_W'(year);
    t.now_month    = MONTH_W'(month);
    t.now_day      = DAY_W'(day);
    t.clock_hour   = HOUR_W'(hour);
    t.clock_minute = MINUTE_W'(minute);
    t.mark_fired   = mark;
    return t;
  endfunction

  function automatic logic [SLOT_W-1:0] make_slot(int hour, int minute);
    return {MINUTE_W'(minute), HOUR_W'(hour)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_alarm_times();
    logic [CFG_DATA_W-1:0] v;
    logic [SLOT_W-1:0]     s;
    int                    i;
    v = '0;
    for (i = 0; i < ALARM_COUNT_MAX; i++) begin
      // shared times give ties in both the match and the nearest search
      if (i > 0 && $urandom_range(99) < 35) begin
        s = v[SLOT_W*(i-1) +: SLOT_W];
      end else if ($urandom_range(99) < 10) begin
        s = SLOT_W'($urandom);
      end else begin
        s = make_slot($urandom_range(23), $urandom_range(59));
      end
      v[SLOT_W*i +: SLOT_W] = s;
    end
    return v;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    kind;
    int    slot;
    kind = $urandom_range(99);
    if (have_last && kind < 25) begin
      // same date-time again, to reach the fired-record paths
      t = last_tick;
    end else begin
      if ($urandom_range(99) < 15) begin
        t.now_year  = YEAR_W'($urandom);
        t.now_month = MONTH_W'($urandom);
        t.now_day   = DAY_W'($urandom);
      end else begin
        t.now_year  = YEAR_W'($urandom_range(2026, 2024));
        t.now_month = MONTH_W'($urandom_range(12, 1));
        t.now_day   = DAY_W'($urandom_range(3, 1));
      end
      kind = $urandom_range(99);
      if (kind < 50) begin
        slot = $urandom_range(ALARM_COUNT_MAX - 1);
        t.clock_hour   = sb.alarm_times[SLOT_W*slot +: HOUR_W];
        t.clock_minute = sb.alarm_times[SLOT_W*slot + HOUR_W +: MINUTE_W];
        if ($urandom_range(99) < 30) begin
          t.clock_minute = $urandom_range(1) ? t.clock_minute + 1'b1
                                             : t.clock_minute - 1'b1;
        end
      end else if (kind < 85) begin
        t.clock_hour   = HOUR_W'($urandom_range(23));
        t.clock_minute = MINUTE_W'($urandom_range(59));
      end else begin
        t.clock_hour   = HOUR_W'($urandom);
        t.clock_minute = MINUTE_W'($urandom);
      end
    end
    t.mark_fired = 1'($urandom_range(1));
    last_tick = t;
    have_last = 1'b1;
    return t;
  endfunction

  // called and returns at a falling edge
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid = 1'b0;
      @(negedge clk);
    end
    tick_ch.valid = 1'b1;
    tick_ch.data  = t;
    forever begin
      @(posedge clk);
      if (tick_ch.ready) break;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic wait_drained();
    tick_ch.valid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_directed();
    write_reg(REG_ENABLE_MASK, CFG_DATA_W'(4'b1111));
    write_reg(REG_ALARM_TIMES, {make_slot(0, 0), make_slot(23, 59), make_slot(7, 30),
                                make_slot(7, 30)});
    send_tick(make_tick(0, 0, 0, 0, 0, 1'b0));  // zero date before any record is valid
    send_tick(make_tick(2024, 6, 15, 7, 30, 1'b0));
    send_tick(make_tick(2024, 6, 15, 7, 30, 1'b1));
    send_tick(make_tick(2024, 6, 15, 7, 30, 1'b0));
    send_tick(make_tick(2025, 6, 15, 7, 30, 1'b0));
    send_tick(make_tick(2024, 6, 15, 7, 29, 1'b0));
    send_tick(make_tick(2024, 6, 15, 23, 59, 1'b1));
    send_tick(make_tick(2024, 6, 15, 23, 59, 1'b0));
    send_tick(make_tick(2024, 6, 16, 0, 0, 1'b0));
    send_tick(make_tick(0, 1, 1, 0, 0, 1'b0));
    send_tick(make_tick(9999, 12, 31, 23, 59, 1'b0));
    send_tick(make_tick(16383, 15, 31, 31, 63, 1'b0));
    send_tick(make_tick(0, 0, 0, 0, 0, 1'b1));
    send_tick(make_tick(0, 0, 0, 0, 0, 1'b0));
    send_tick(make_tick(2024, 6, 15, 24, 0, 1'b0));
    send_tick(make_tick(2024, 6, 15, 7, 60, 1'b0));
    wait_drained();
    // partial mask: only one of the tied slots is live
    write_reg(REG_ENABLE_MASK, CFG_DATA_W'(4'b0101));
    send_tick(make_tick(2024, 6, 15, 7, 30, 1'b0));
    send_tick(make_tick(2024, 6, 15, 12, 0, 1'b0));
    wait_drained();
    write_reg(REG_ENABLE_MASK, CFG_DATA_W'(4'b0000));
    send_tick(make_tick(2024, 6, 15, 7, 30, 1'b0));
    send_tick(make_tick(2024, 6, 15, 31, 63, 1'b0));
    wait_drained();
    // every slot at the out-of-range maximum time
    write_reg(REG_ENABLE_MASK, CFG_DATA_W'(4'b1111));
    write_reg(REG_ALARM_TIMES, '1);
    send_tick(make_tick(2024, 6, 15, 23, 59, 1'b0));
    send_tick(make_tick(2024, 6, 15, 31, 63, 1'b1));
    send_tick(make_tick(2024, 6, 15, 31, 63, 1'b0));
    wait_drained();
  endtask

  initial begin
    int p;
    int n;
    sb = new();
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_ENABLE_MASK;
    cfg_data      = '0;
    tick_ch.valid = 1'b0;
    tick_ch.data  = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    run_directed();

    for (p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          write_reg(REG_ENABLE_MASK, CFG_DATA_W'(4'b1111));
          write_reg(REG_ALARM_TIMES, '1);
        end
        1: begin
          write_reg(REG_ENABLE_MASK, '0);
          write_reg(REG_ALARM_TIMES, random_alarm_times());
        end
        2: begin
          write_reg(REG_ENABLE_MASK, CFG_DATA_W'(4'b1111));
          write_reg(REG_ALARM_TIMES, '0);
        end
        default: begin
          write_reg(REG_ENABLE_MASK,
                    $urandom_range(1) ? CFG_DATA_W'(4'b1111) : CFG_DATA_W'($urandom_range(15)));
          write_reg(REG_ALARM_TIMES, random_alarm_times());
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_tick(random_tick());
      wait_drained();
    end

    if (sb.failures == 0) begin
      $display("alarm_match_and_next_finder_tb: PASS");
    end else begin
      $display("alarm_match_and_next_finder_tb: FAIL");
    end
    $finish;
  end

endmodule
